[rtl/core/scn_pkg.sv]
// Shared types and constants of the step counter normaliser core.
`timescale 1ns / 1ps
`default_nettype none

package scn_pkg;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 5;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 13;

  localparam logic [2:0] SOURCE_COUNT = 3'd3;

  localparam logic [2:0] REG_COUNTER_IS_WIDE = 3'd0;
  localparam logic [2:0] REG_MAX_JUMP        = 3'd1;
  localparam logic [2:0] REG_MAX_GAP_MS      = 3'd2;
  localparam logic [2:0] REG_WRAP_HIGH       = 3'd3;
  localparam logic [2:0] REG_WRAP_LOW        = 3'd4;

  localparam logic [63:0] RST_MAX_JUMP   = 64'd10000;
  localparam logic [63:0] RST_MAX_GAP_MS = 64'd60000;
  localparam logic [63:0] RST_WRAP_HIGH  = 64'd4026531840;
  localparam logic [63:0] RST_WRAP_LOW   = 64'd268435455;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_TIME_REGR  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    RSN_NONE        = 4'd0,
    RSN_STALE       = 4'd1,
    RSN_UNAVAILABLE = 4'd2,
    RSN_BASELINE    = 4'd3,
    RSN_SOURCE      = 4'd4,
    RSN_GAP         = 4'd5,
    RSN_JUMP        = 4'd6,
    RSN_WRAP        = 4'd7,
    RSN_RESET       = 4'd8,
    RSN_DELTA       = 4'd9
  } reason_t;

  // Packed from the top down, so accepted lands in bit 0.
  typedef struct packed {
    logic wrapped;
    logic source_changed;
    logic unavailable;
    logic stale;
    logic discontinuity;
    logic rebased;
    logic accepted;
  } flags_t;

endpackage

`default_nettype wire

[rtl/core/step_counter_normalizer_core.sv]
// Step counter normaliser: turns raw counter samples into a 64-bit step total.
//
//  channel  direction  handshake          payload
//  in_      slave      tvalid / tready    tdata: raw_count, time_ms
//                                         tuser: sample_source, available, fresh
//  out_     master     tvalid / tready    tdata: step_delta, step_total
//                                         tuser: status, reason, flags
//  cfg_     APB slave  psel / penable     64-bit registers at byte address 8*i
//
// A sample is registered on acceptance and its result is registered in the
// output register, and a sample can be taken every cycle unless out_tready stalls.
// The running state is updated at the same edge as the result register, so
// the next sample always sees the state left by the one before it.
// Reset is synchronous and active low; it clears state and loads configuration defaults.
// When the result register is held by out_tready low, the input register
// holds too and in_tready falls once both are full.
`timescale 1ns / 1ps
`default_nettype none

module step_counter_normalizer_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [63:0] raw_count, [127:64] time_ms
  input  wire  [scn_pkg::IN_DATA_W-1:0]    in_tdata,
  // [2:0] sample_source, [3] available, [4] fresh
  input  wire  [scn_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [63:0] step_delta, [127:64] step_total
  output logic [scn_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] status, [5:2] reason, [6] accepted, [7] rebased, [8] discontinuity,
  // [9] stale, [10] unavailable, [11] source changed, [12] wrapped
  output logic [scn_pkg::OUT_USER_W-1:0]   out_tuser,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [scn_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [scn_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [scn_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  import scn_pkg::*;

  logic        wide_r;
  logic [63:0] max_jump_r;
  logic [63:0] max_gap_r;
  logic [63:0] wrap_high_r;
  logic [63:0] wrap_low_r;

  logic [63:0] running_total_r;
  logic [63:0] base_count_r;
  logic [2:0]  base_source_r;
  logic        base_valid_r;
  logic        time_valid_r;
  logic [63:0] last_time_r;

  logic                  s1_valid_r;
  logic [IN_DATA_W-1:0]  s1_data_r;
  logic [IN_USER_W-1:0]  s1_user_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  logic [2:0]  src;
  logic [63:0] raw;
  logic [63:0] t;
  logic        avail;
  logic        fresh;

  logic        bad_sample;
  logic        time_regr;
  logic [64:0] cnt_diff;
  logic        raw_ge_base;
  logic [63:0] wrap_delta;
  logic [63:0] sel_delta;
  logic [64:0] sum;
  logic [63:0] gap;
  logic        wrap_ok;

  status_t     status;
  reason_t     reason;
  flags_t      flags;
  logic [63:0] delta_out;
  logic        upd_time;
  logic [63:0] total_nxt;
  logic [63:0] base_count_nxt;
  logic [2:0]  base_source_nxt;
  logic        base_valid_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];

  always_comb begin
    case (cfg_idx)
      REG_COUNTER_IS_WIDE: cfg_prdata = {63'd0, wide_r};
      REG_MAX_JUMP:        cfg_prdata = max_jump_r;
      REG_MAX_GAP_MS:      cfg_prdata = max_gap_r;
      REG_WRAP_HIGH:       cfg_prdata = wrap_high_r;
      REG_WRAP_LOW:        cfg_prdata = wrap_low_r;
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r      <= 1'b0;
      max_jump_r  <= RST_MAX_JUMP;
      max_gap_r   <= RST_MAX_GAP_MS;
      wrap_high_r <= RST_WRAP_HIGH;
      wrap_low_r  <= RST_WRAP_LOW;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COUNTER_IS_WIDE: wide_r      <= cfg_pwdata[0];
        REG_MAX_JUMP:        max_jump_r  <= cfg_pwdata;
        REG_MAX_GAP_MS:      max_gap_r   <= cfg_pwdata;
        REG_WRAP_HIGH:       wrap_high_r <= cfg_pwdata;
        REG_WRAP_LOW:        wrap_low_r  <= cfg_pwdata;
        default:             ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  assign raw   = s1_data_r[63:0];
  assign t     = s1_data_r[127:64];
  assign src   = s1_user_r[2:0];
  assign avail = s1_user_r[3];
  assign fresh = s1_user_r[4];

  assign bad_sample  = (src == 3'd0) || (src >= SOURCE_COUNT) ||
                       (!wide_r && (raw[63:32] != 32'd0));
  assign time_regr   = time_valid_r && (t < last_time_r);
  assign cnt_diff    = {1'b0, raw} - {1'b0, base_count_r};
  assign raw_ge_base = !cnt_diff[64];
  // A narrow counter wraps at 2^32; a wide one wraps modulo 2^64.
  assign wrap_delta  = cnt_diff[63:0] + {31'd0, !wide_r, 32'd0};
  assign sel_delta   = raw_ge_base ? cnt_diff[63:0] : wrap_delta;
  assign sum         = {1'b0, running_total_r} + {1'b0, sel_delta};
  assign gap         = t - last_time_r;
  assign wrap_ok     = (base_count_r >= wrap_high_r) && (raw <= wrap_low_r) &&
                       (wrap_delta <= max_jump_r);

  always_comb begin
    status          = ST_OK;
    reason          = RSN_NONE;
    flags           = '0;
    delta_out       = '0;
    upd_time        = 1'b0;
    total_nxt       = running_total_r;
    base_count_nxt  = base_count_r;
    base_source_nxt = base_source_r;
    base_valid_nxt  = base_valid_r;
    if (bad_sample) begin
      status = ST_INVALID;
    end else if (time_regr) begin
      status = ST_TIME_REGR;
    end else if (!avail || !fresh) begin
      upd_time            = 1'b1;
      base_valid_nxt      = 1'b0;
      flags.rebased       = 1'b1;
      flags.discontinuity = 1'b1;
      if (avail) begin
        reason      = RSN_STALE;
        flags.stale = 1'b1;
      end else begin
        reason            = RSN_UNAVAILABLE;
        flags.unavailable = 1'b1;
      end
    end else if (!base_valid_r) begin
      upd_time        = 1'b1;
      base_valid_nxt  = 1'b1;
      base_count_nxt  = raw;
      base_source_nxt = src;
      reason          = RSN_BASELINE;
      flags.accepted  = 1'b1;
      flags.rebased   = 1'b1;
    end else if (src != base_source_r) begin
      upd_time             = 1'b1;
      base_count_nxt       = raw;
      base_source_nxt      = src;
      reason               = RSN_SOURCE;
      flags.accepted       = 1'b1;
      flags.rebased        = 1'b1;
      flags.discontinuity  = 1'b1;
      flags.source_changed = 1'b1;
    end else if (gap > max_gap_r) begin
      upd_time            = 1'b1;
      base_count_nxt      = raw;
      reason              = RSN_GAP;
      flags.accepted      = 1'b1;
      flags.rebased       = 1'b1;
      flags.discontinuity = 1'b1;
    end else if (raw_ge_base) begin
      if (cnt_diff[63:0] > max_jump_r) begin
        upd_time            = 1'b1;
        base_count_nxt      = raw;
        reason              = RSN_JUMP;
        flags.accepted      = 1'b1;
        flags.rebased       = 1'b1;
        flags.discontinuity = 1'b1;
      end else if (sum[64]) begin
        status = ST_OVERFLOW;
      end else begin
        upd_time       = 1'b1;
        total_nxt      = sum[63:0];
        base_count_nxt = raw;
        delta_out      = sel_delta;
        reason         = RSN_DELTA;
        flags.accepted = 1'b1;
      end
    end else if (wrap_ok) begin
      if (sum[64]) begin
        status = ST_OVERFLOW;
      end else begin
        upd_time       = 1'b1;
        total_nxt      = sum[63:0];
        base_count_nxt = raw;
        delta_out      = sel_delta;
        reason         = RSN_WRAP;
        flags.accepted = 1'b1;
        flags.wrapped  = 1'b1;
      end
    end else begin
      upd_time            = 1'b1;
      base_count_nxt      = raw;
      reason              = RSN_RESET;
      flags.accepted      = 1'b1;
      flags.rebased       = 1'b1;
      flags.discontinuity = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_total_r <= '0;
      base_count_r    <= '0;
      base_source_r   <= '0;
      base_valid_r    <= 1'b0;
      time_valid_r    <= 1'b0;
      last_time_r     <= '0;
    end else if (s1_fire) begin
      running_total_r <= total_nxt;
      base_count_r    <= base_count_nxt;
      base_source_r   <= base_source_nxt;
      base_valid_r    <= base_valid_nxt;
      if (upd_time) begin
        time_valid_r <= 1'b1;
        last_time_r  <= t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {total_nxt, delta_out};
      out_user_r <= {flags, reason, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

[tb/tb_step_counter_normalizer_core.sv]
// Self-checking testbench for the step counter normaliser core, with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_step_counter_normalizer_core;
  import scn_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] delta;
    logic [63:0] total;
    reason_t     reason;
    flags_t      flags;
  } step_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  step_counter_normalizer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Register copies and running state of the predictor.
  logic        reg_wide;
  logic [63:0] reg_jump;
  logic [63:0] reg_gap;
  logic [63:0] reg_wrap_hi;
  logic [63:0] reg_wrap_lo;
  logic [63:0] acc_total;
  logic [63:0] base_cnt;
  logic [2:0]  base_src;
  logic        base_ok;
  logic        time_ok;
  logic [63:0] last_ms;

  step_result_t pending[$];

  logic [63:0] now_ms;
  logic [63:0] seq_raw;
  logic [2:0]  seq_src;
  bit          tx_random;
  bit          rx_random;
  int          rx_hold;
  int          errors;
  int          n_checked;
  int          n_wraps;
  int          n_overflows;
  int          n_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic step_result_t normalise(logic [2:0] src, logic [63:0] raw,
                                             logic [63:0] t, logic av, logic fr);
    step_result_t r;
    logic [63:0]  cmax;
    logic [63:0]  d;
    cmax     = reg_wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    r.status = ST_OK;
    r.delta  = '0;
    r.reason = RSN_NONE;
    r.flags  = '0;
    if (src < 3'd1 || src >= SOURCE_COUNT || raw > cmax) begin
      r.status = ST_INVALID;
    end else if (time_ok && t < last_ms) begin
      r.status = ST_TIME_REGR;
    end else if (!av || !fr) begin
      base_ok = 1'b0;
      r.flags.rebased       = 1'b1;
      r.flags.discontinuity = 1'b1;
      if (av) begin
        r.reason      = RSN_STALE;
        r.flags.stale = 1'b1;
      end else begin
        r.reason            = RSN_UNAVAILABLE;
        r.flags.unavailable = 1'b1;
      end
    end else if (!base_ok) begin
      base_ok  = 1'b1;
      base_cnt = raw;
      base_src = src;
      r.reason = RSN_BASELINE;
      r.flags.accepted = 1'b1;
      r.flags.rebased  = 1'b1;
    end else if (src != base_src) begin
      base_cnt = raw;
      base_src = src;
      r.reason = RSN_SOURCE;
      r.flags.accepted       = 1'b1;
      r.flags.rebased        = 1'b1;
      r.flags.discontinuity  = 1'b1;
      r.flags.source_changed = 1'b1;
    end else if (t - last_ms > reg_gap) begin
      base_cnt = raw;
      r.reason = RSN_GAP;
      r.flags.accepted      = 1'b1;
      r.flags.rebased       = 1'b1;
      r.flags.discontinuity = 1'b1;
    end else if (raw >= base_cnt) begin
      d = raw - base_cnt;
      if (d > reg_jump) begin
        base_cnt = raw;
        r.reason = RSN_JUMP;
        r.flags.accepted      = 1'b1;
        r.flags.rebased       = 1'b1;
        r.flags.discontinuity = 1'b1;
      end else if (d > ~acc_total) begin
        r.status = ST_OVERFLOW;
      end else begin
        acc_total = acc_total + d;
        base_cnt  = raw;
        r.delta   = d;
        r.reason  = RSN_DELTA;
        r.flags.accepted = 1'b1;
      end
    end else begin
      d = (cmax - base_cnt) + 64'd1 + raw;
      if (base_cnt >= reg_wrap_hi && raw <= reg_wrap_lo && d <= reg_jump) begin
        if (d > ~acc_total) begin
          r.status = ST_OVERFLOW;
        end else begin
          acc_total = acc_total + d;
          base_cnt  = raw;
          r.delta   = d;
          r.reason  = RSN_WRAP;
          r.flags.accepted = 1'b1;
          r.flags.wrapped  = 1'b1;
        end
      end else begin
        base_cnt = raw;
        r.reason = RSN_RESET;
        r.flags.accepted      = 1'b1;
        r.flags.rebased       = 1'b1;
        r.flags.discontinuity = 1'b1;
      end
    end
    if (r.status == ST_OK) begin
      time_ok = 1'b1;
      last_ms = t;
    end
    r.total = acc_total;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(4, 25);
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result checker: every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        $error("result transaction with no sample outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        n_checked++;
        if (e.reason == RSN_WRAP) n_wraps++;
        if (e.status == ST_OVERFLOW) n_overflows++;
        compare_field("status", 64'(e.status), 64'(out_tuser[1:0]));
        compare_field("step_delta", e.delta, out_tdata[63:0]);
        compare_field("step_total", e.total, out_tdata[127:64]);
        compare_field("reason", 64'(e.reason), 64'(out_tuser[5:2]));
        compare_field("flag_accepted", 64'(e.flags.accepted), 64'(out_tuser[6]));
        compare_field("flag_rebased", 64'(e.flags.rebased), 64'(out_tuser[7]));
        compare_field("flag_discontinuity", 64'(e.flags.discontinuity),
                      64'(out_tuser[8]));
        compare_field("flag_stale", 64'(e.flags.stale), 64'(out_tuser[9]));
        compare_field("flag_unavailable", 64'(e.flags.unavailable), 64'(out_tuser[10]));
        compare_field("flag_source_changed", 64'(e.flags.source_changed),
                      64'(out_tuser[11]));
        compare_field("flag_wrapped", 64'(e.flags.wrapped), 64'(out_tuser[12]));
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        if (rx_random && $urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  task automatic send_sample(logic [2:0] src, logic [63:0] raw, logic [63:0] t,
                             logic av, logic fr);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {t, raw};
    in_tuser  = {fr, av, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending.push_back(normalise(src, raw, t, av, fr));
  endtask

  task automatic feed(logic [2:0] src, logic [63:0] raw, logic [63:0] dt, logic av, logic fr);
    now_ms = now_ms + dt;
    send_sample(src, raw, now_ms, av, fr);
  endtask

  task automatic idle_in(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  task automatic settle();
    idle_in(1);
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    case (idx)
      REG_COUNTER_IS_WIDE: reg_wide    = val[0];
      REG_MAX_JUMP:        reg_jump    = val;
      REG_MAX_GAP_MS:      reg_gap     = val;
      REG_WRAP_HIGH:       reg_wrap_hi = val;
      REG_WRAP_LOW:        reg_wrap_lo = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic apply_settings(logic wide, logic [63:0] jump, logic [63:0] gap,
                                logic [63:0] wh, logic [63:0] wl);
    settle();
    cfg_write(REG_COUNTER_IS_WIDE, {63'd0, wide});
    cfg_write(REG_MAX_JUMP, jump);
    cfg_write(REG_MAX_GAP_MS, gap);
    cfg_write(REG_WRAP_HIGH, wh);
    cfg_write(REG_WRAP_LOW, wl);
  endtask

  task automatic apply_random_settings();
    logic        wide;
    logic [63:0] jump;
    logic [63:0] gap;
    logic [63:0] wh;
    logic [63:0] wl;
    logic [63:0] cm;
    wide = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: jump = 64'd1;
      1: jump = 64'($urandom_range(2, 100));
      2: jump = RST_MAX_JUMP;
      3: jump = 64'($urandom_range(10001, 1 << 20));
      default: jump = '1;
    endcase
    // A very wide jump limit on a 64-bit counter would saturate the total early.
    if (jump == '1) wide = 1'b0;
    case ($urandom_range(0, 3))
      0: gap = 64'd1;
      1: gap = 64'($urandom_range(50, 2000));
      2: gap = RST_MAX_GAP_MS;
      default: gap = '1;
    endcase
    cm = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    case ($urandom_range(0, 3))
      0: wh = '0;
      1: wh = cm;
      default: wh = cm - 64'($urandom_range(0, 1 << 28));
    endcase
    case ($urandom_range(0, 3))
      0: wl = '0;
      1: wl = '1;
      default: wl = 64'($urandom_range(0, 1 << 28));
    endcase
    apply_settings(wide, jump, gap, wh, wl);
  endtask

  task automatic random_samples(int n);
    logic [63:0] cmax;
    logic [63:0] raw;
    logic [63:0] t;
    logic [63:0] hi;
    logic [63:0] inc_hi;
    logic [2:0]  src;
    logic        av;
    logic        fr;
    int          k;
    int          gap;
    for (int i = 0; i < n; i++) begin
      cmax   = reg_wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      hi     = (reg_jump < 64'd3000) ? reg_jump + 64'd1 : 64'd3000;
      inc_hi = (reg_gap < 64'd400) ? reg_gap : 64'd400;
      k      = $urandom_range(0, 99);
      src    = seq_src;
      av     = 1'b1;
      fr     = 1'b1;
      raw    = (seq_raw + 64'($urandom_range(0, hi[31:0]))) & cmax;
      if ($urandom_range(0, 99) < 92 || reg_gap > 64'd1_000_000)
        now_ms = now_ms + 64'($urandom_range(0, inc_hi[31:0]));
      else
        now_ms = now_ms + reg_gap + 64'($urandom_range(1, 50));
      t = now_ms;
      if (k >= 70 && k < 78) begin
        raw = cmax - 64'($urandom_range(0, 100));
      end else if (k >= 78 && k < 84) begin
        raw = (seq_raw - 64'($urandom_range(1, 200))) & cmax;
      end else if (k >= 84 && k < 88) begin
        raw = (seq_raw + reg_jump + 64'($urandom_range(1, 1000))) & cmax;
      end else if (k >= 88 && k < 92) begin
        src = (seq_src == 3'd1) ? 3'd2 : 3'd1;
      end else if (k >= 92 && k < 96) begin
        av = 1'($urandom_range(0, 1));
        fr = av ? 1'b0 : 1'($urandom_range(0, 1));
      end else if (k >= 96) begin
        src = 3'($urandom_range(0, 7));
        raw = $urandom_range(0, 1) ? {$urandom, $urandom} : {32'd0, $urandom};
        av  = 1'($urandom_range(0, 1));
        fr  = 1'($urandom_range(0, 1));
        t   = now_ms - 64'($urandom_range(0, 30));
      end
      send_sample(src, raw, t, av, fr);
      if (src == 3'd1 || src == 3'd2) seq_src = src;
      if (raw <= cmax) seq_raw = raw;
      if (tx_random) begin
        gap = pick_gap();
        if (gap > 0) idle_in(gap);
      end
    end
  endtask

  task automatic test_default_settings();
    feed(3'd0, 64'd5, 64'd10, 1'b1, 1'b1);
    feed(3'd7, 64'd5, 64'd0, 1'b1, 1'b1);
    feed(3'd1, 64'h1_0000_0000, 64'd0, 1'b1, 1'b1);
    feed(3'd1, 64'd100, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'd150, 64'd100, 1'b1, 1'b1);
    send_sample(3'd1, 64'd160, now_ms - 64'd1, 1'b1, 1'b1);
    feed(3'd1, 64'd170, 64'd0, 1'b1, 1'b1);
    feed(3'd1, 64'd175, 64'd10, 1'b1, 1'b0);
    feed(3'd1, 64'd180, 64'd10, 1'b0, 1'b1);
    feed(3'd1, 64'd200, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'd300, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'd310, 64'd60001, 1'b1, 1'b1);
    feed(3'd2, 64'd10311, 64'd60000, 1'b1, 1'b1);
    feed(3'd2, 64'd20311, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'hFFFF_FFF0, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'd5, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'd2, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'hFFFF_FFFF, 64'd10, 1'b1, 1'b1);
    feed(3'd2, 64'd0, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'd7, 64'd10, 1'b0, 1'b0);
  endtask

  task automatic test_wide_counter();
    apply_settings(1'b1, 64'd1000, 64'd5000, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF);
    feed(3'd1, 64'h1_0000_0000, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'hFFFF_FFFF_FFFF_FFF0, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'd3, 64'd10, 1'b1, 1'b1);
    feed(3'd1, 64'h1_0000, 64'd10, 1'b1, 1'b1);
    feed(3'd2, {$urandom, $urandom}, 64'd10, 1'b1, 1'b1);
  endtask

  task automatic test_minimum_settings();
    apply_settings(1'b0, 64'd1, 64'd1, '1, '0);
    feed(3'd2, 64'd50, 64'd1, 1'b1, 1'b1);
    feed(3'd2, 64'd51, 64'd1, 1'b1, 1'b1);
    feed(3'd2, 64'd53, 64'd0, 1'b1, 1'b1);
    feed(3'd2, 64'd53, 64'd2, 1'b1, 1'b1);
    feed(3'd2, 64'd40, 64'd1, 1'b1, 1'b1);
    feed(3'd2, 64'd0, 64'd1, 1'b1, 1'b1);
    seq_src = 3'd2;
    seq_raw = 64'd0;
  endtask

  task automatic test_backpressure();
    apply_settings(1'b0, RST_MAX_JUMP, RST_MAX_GAP_MS, RST_WRAP_HIGH, RST_WRAP_LOW);
    rx_hold = 60;
    for (int i = 0; i < 30; i++) begin
      seq_raw = seq_raw + 64'($urandom_range(0, 50));
      feed(seq_src, seq_raw, 64'($urandom_range(0, 100)), 1'b1, 1'b1);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      apply_random_settings();
      tx_random = (p != 0);
      rx_random = (p != 0);
      random_samples(125);
    end
    tx_random = 1'b0;
    rx_random = 1'b0;
  endtask

  // Runs last, since it leaves the total saturated and the timestamp at its maximum.
  task automatic test_limits();
    apply_settings(1'b1, '1, '1, '0, '1);
    feed(3'd1, 64'd0, 64'd1, 1'b0, 1'b1);
    feed(3'd1, 64'd0, 64'd1, 1'b1, 1'b1);
    feed(3'd1, ~acc_total, 64'd1, 1'b1, 1'b1);
    feed(3'd1, base_cnt + 64'd1, 64'd1, 1'b1, 1'b1);
    feed(3'd1, 64'd0, 64'd1, 1'b1, 1'b1);
    feed(3'd1, base_cnt, 64'd1, 1'b1, 1'b1);
    send_sample(3'd1, base_cnt, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_sample(3'd1, base_cnt, 64'd0, 1'b1, 1'b1);
    send_sample(3'd0, '1, '1, 1'b0, 1'b0);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL step_counter_normalizer_core");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    reg_wide    = 1'b0;
    reg_jump    = RST_MAX_JUMP;
    reg_gap     = RST_MAX_GAP_MS;
    reg_wrap_hi = RST_WRAP_HIGH;
    reg_wrap_lo = RST_WRAP_LOW;
    acc_total   = '0;
    base_cnt    = '0;
    base_src    = '0;
    base_ok     = 1'b0;
    time_ok     = 1'b0;
    last_ms     = '0;
    now_ms      = 64'd1000;
    seq_raw     = '0;
    seq_src     = 3'd1;
    tx_random   = 1'b0;
    rx_random   = 1'b0;
    rx_hold     = 0;
    errors      = 0;
    n_checked   = 0;
    n_wraps     = 0;
    n_overflows = 0;
    n_writes    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_settings();
    test_wide_counter();
    test_minimum_settings();
    test_backpressure();
    test_random_traffic();
    test_limits();

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d result transactions across %0d register writes,", n_checked, n_writes);
    $display("including %0d counter wraps and %0d overflows.", n_wraps, n_overflows);
    if (errors == 0) begin
      $display("PASS step_counter_normalizer_core");
    end else begin
      $display("FAIL step_counter_normalizer_core");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/scn_pkg.sv
rtl/core/step_counter_normalizer_core.sv
tb/tb_step_counter_normalizer_core.sv
